[hw/rtl/sct_pkg.sv]
// Shared constants for the shot credit tracker.
`default_nettype none

package sct_pkg;

   // Field widths of the stream words.
   localparam int COUNT_W    = 8;
   localparam int COOL_W     = 8;
   localparam int ELAPSED_W  = 20;
   localparam int INTERVAL_W = 20;
   localparam int TIME_W     = 28;

   // Time constants, microsecond units; the default cooling time is in seconds.
   localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0] US_PER_S  = TIME_W'(1000000);
   localparam logic [COOL_W-1:0] DEFAULT_COOLING_S = COOL_W'(2);

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_MAX_VALID_COUNT  = 2'd0;
   localparam logic [1:0] CSR_OFFLINE_DEFAULT  = 2'd1;
   localparam logic [1:0] CSR_SHOT_INTERVAL_US = 2'd2;

   // Register values after reset.
   localparam logic [COUNT_W-1:0]    MAX_VALID_RESET  = COUNT_W'(200);
   localparam logic [COUNT_W-1:0]    OFFLINE_RESET    = COUNT_W'(100);
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = INTERVAL_W'(100000);

endpackage

`default_nettype wire

[hw/rtl/shot_credit_tracker_unit.sv]
// Shot credit tracker: count filter, pending shot timers and shot scheduler.
//
// Usage: one word on the req_ stream is one control tick. The unit filters
// the reported count, retires pending shots on a count drop, ages the
// pending shot timers, retires the leading timers that reached the cooling
// time and schedules at most one feeder step. Each tick gives one rsp_ word.
// Timers live in a circular buffer held in a one-port-read, one-port-write
// synchronous memory; each pending timer is read in S_READ and written in S_MOD.
// A firing tick with a nonzero estimate walks S_PREP, S_CHK, an S_READ and
// S_MOD pair for each pending shot (at most PENDING_DEPTH), S_EXP, S_FIRE and
// S_DONE. A released trigger goes from S_PREP to S_DONE, an empty estimate
// from S_PREP through S_CHK to S_DONE. req_tready rises in the same cycle as
// rsp_tvalid. One tick is worked on at a time; req_tready is high whenever
// no tick is in progress, also while a result waits to be taken.
// If rsp_tready is low the finished tick waits in its last state until the
// output register is free. Reset clears the counters and the accumulator and
// restores the register defaults; the timer memory needs no clearing pass.
// The user must write registers through the csr_ port only while the unit is
// idle; the unit itself does not enforce this.
`default_nettype none

module shot_credit_tracker_unit #(
   parameter int PENDING_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // reported_count[7:0], cooling_seconds[15:8], referee_online[16],
   // fire_held[17], elapsed_us[37:18], zero fill
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // motor_run[0], advance_one[1], remaining_estimate[9:2],
   // pending_count_out above, zero fill
   output logic [((10 + $clog2(PENDING_DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int RSP_W = ((10 + CW + 7) / 8) * 8;
   localparam int TW = sct_pkg::TIME_W;
   localparam logic [AW:0]   DEPTH_A = (AW + 1)'(PENDING_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

   // Tick sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_MOD  = 3'd4;
   localparam logic [2:0] S_EXP  = 3'd5;
   localparam logic [2:0] S_FIRE = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0] state_ff, state_in;

   // Configuration registers.
   logic [7:0]  max_valid_ff;
   logic [7:0]  offline_def_ff;
   logic [19:0] interval_ff;

   // Tick operands.
   logic [7:0]    count_ff, count_in;
   logic [19:0]   elapsed_ff, elapsed_in;
   logic [TW-1:0] cool_us_ff, cool_us_in;
   logic          fire_ff, fire_in;

   // Tracker state.
   logic [7:0]    last_count_ff, last_count_in;
   logic [7:0]    remaining_ff, remaining_in;
   logic [CW-1:0] pending_ff, pending_in;
   logic [AW-1:0] head_ff, head_in;
   logic [TW-1:0] accum_ff, accum_in;
   logic          run_ff, run_in;
   logic          adv_ff, adv_in;

   // Timer walk.
   logic [CW-1:0] walk_idx_ff, walk_idx_in;
   logic [AW-1:0] walk_addr_ff, walk_addr_in;
   logic [CW-1:0] expired_ff, expired_in;
   logic          prefix_ff, prefix_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // Timer memory.
   logic [TW-1:0] pending_age_mem [PENDING_DEPTH];
   logic [TW-1:0] mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [TW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;

   // Input field views.
   logic [7:0]  in_reported;
   logic [7:0]  in_cooling;
   logic        in_online;
   logic        in_fire;
   logic [19:0] in_elapsed;
   logic [7:0]  cool_sel;
   logic        req_fire;
   logic        csr_write;

   // Walk and retire helpers.
   logic [7:0]    drop;
   logic [AW:0]   head_sum;
   logic [AW:0]   head_wrap;
   logic [AW:0]   tail_sum;
   logic [AW:0]   walk_next;
   logic [TW:0]   age_sum;
   logic [TW-1:0] age_sat;
   logic [TW:0]   acc_sum;
   logic [CW-1:0] pend_tmp;
   logic [CW-1:0] walk_last;

   assign in_reported = req_tdata[7:0];
   assign in_cooling  = req_tdata[15:8];
   assign in_online   = req_tdata[16];
   assign in_fire     = req_tdata[17];
   assign in_elapsed  = req_tdata[37:18];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration port: writes complete in the access phase, reads are muxed.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         sct_pkg::CSR_MAX_VALID_COUNT:  csr_prdata = 32'(max_valid_ff);
         sct_pkg::CSR_OFFLINE_DEFAULT:  csr_prdata = 32'(offline_def_ff);
         sct_pkg::CSR_SHOT_INTERVAL_US: csr_prdata = 32'(interval_ff);
         default:                       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_valid_ff   <= sct_pkg::MAX_VALID_RESET;
         offline_def_ff <= sct_pkg::OFFLINE_RESET;
         interval_ff    <= sct_pkg::INTERVAL_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            sct_pkg::CSR_MAX_VALID_COUNT:  max_valid_ff   <= csr_pwdata[7:0];
            sct_pkg::CSR_OFFLINE_DEFAULT:  offline_def_ff <= csr_pwdata[7:0];
            sct_pkg::CSR_SHOT_INTERVAL_US: interval_ff    <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   // Count filter and cooling time, worked out as the word is accepted.
   assign cool_sel = (in_cooling != 8'd0) ? in_cooling : sct_pkg::DEFAULT_COOLING_S;

   always_comb begin
      if (in_reported > max_valid_ff) begin
         count_in = 8'd0;
      end else if (!in_online) begin
         count_in = offline_def_ff;
      end else begin
         count_in = in_reported;
      end
   end

   assign cool_us_in = TW'(cool_sel) * sct_pkg::US_PER_S;
   assign elapsed_in = in_elapsed;
   assign fire_in    = in_fire;

   // Shared arithmetic of the walk.
   assign drop      = last_count_ff - count_ff;
   assign age_sum   = {1'b0, mem_rdata_ff} + (TW + 1)'(elapsed_ff);
   assign age_sat   = age_sum[TW] ? sct_pkg::TIME_MAX : age_sum[TW-1:0];
   assign acc_sum   = {1'b0, accum_ff} + (TW + 1)'(elapsed_ff);
   assign walk_next = {1'b0, walk_addr_ff} + (AW + 1)'(1);
   assign tail_sum  = {1'b0, head_ff} + (AW + 1)'(pending_ff);
   assign walk_last = CW'(walk_idx_ff + CW'(1));

   // Head advance amount: count drop in the prepare step, expired run later.
   always_comb begin
      if (state_ff == S_PREP) begin
         head_sum = {1'b0, head_ff} + (AW + 1)'(drop);
      end else begin
         head_sum = {1'b0, head_ff} + (AW + 1)'(expired_ff);
      end
      head_wrap = (head_sum >= DEPTH_A) ? head_sum - DEPTH_A : head_sum;
   end

   // Tick sequencer.
   always_comb begin
      state_in      = state_ff;
      last_count_in = last_count_ff;
      remaining_in  = remaining_ff;
      pending_in    = pending_ff;
      head_in       = head_ff;
      accum_in      = accum_ff;
      run_in        = run_ff;
      adv_in        = adv_ff;
      walk_idx_in   = walk_idx_ff;
      walk_addr_in  = walk_addr_ff;
      expired_in    = expired_ff;
      prefix_in     = prefix_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = walk_addr_ff;
      mem_wdata     = age_sat;
      mem_re        = 1'b0;
      mem_raddr     = walk_addr_ff;
      pend_tmp      = pending_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_PREP;
            end
         end

         // Fire released, or retire shots on a count drop.
         S_PREP: begin
            run_in = 1'b0;
            adv_in = 1'b0;
            if (!fire_ff) begin
               pending_in   = '0;
               remaining_in = count_ff;
               accum_in     = '0;
               state_in     = S_DONE;
            end else begin
               if (count_ff < last_count_ff) begin
                  if (drop >= 8'(pending_ff)) begin
                     pend_tmp = '0;
                  end else begin
                     pend_tmp = pending_ff - CW'(drop);
                     head_in  = head_wrap[AW-1:0];
                  end
               end
               pending_in   = pend_tmp;
               remaining_in = (count_ff > 8'(pend_tmp)) ? count_ff - 8'(pend_tmp) : 8'd0;
               state_in     = S_CHK;
            end
         end

         // Nothing left: hold off. Otherwise age the accumulator and walk timers.
         S_CHK: begin
            if (remaining_ff == 8'd0) begin
               accum_in = '0;
               state_in = S_DONE;
            end else begin
               run_in       = 1'b1;
               accum_in     = acc_sum[TW] ? sct_pkg::TIME_MAX : acc_sum[TW-1:0];
               walk_idx_in  = '0;
               walk_addr_in = head_ff;
               expired_in   = '0;
               prefix_in    = 1'b1;
               state_in     = (pending_ff == '0) ? S_EXP : S_READ;
            end
         end

         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_MOD;
         end

         // Write back the aged timer and extend the leading expired run.
         S_MOD: begin
            mem_we = 1'b1;
            if (prefix_ff && (age_sat >= cool_us_ff)) begin
               expired_in = expired_ff + CW'(1);
            end else begin
               prefix_in = 1'b0;
            end
            walk_idx_in  = walk_last;
            walk_addr_in = (walk_next == DEPTH_A) ? '0 : walk_next[AW-1:0];
            state_in     = (walk_last == pending_ff) ? S_EXP : S_READ;
         end

         // Retire the expired run.
         S_EXP: begin
            if (expired_ff != '0) begin
               pend_tmp     = pending_ff - expired_ff;
               pending_in   = pend_tmp;
               head_in      = head_wrap[AW-1:0];
               remaining_in = (count_ff > 8'(pend_tmp)) ? count_ff - 8'(pend_tmp) : 8'd0;
            end
            state_in = S_FIRE;
         end

         // Scheduled shot: issue a step and start a new timer if there is room.
         S_FIRE: begin
            if (accum_ff >= TW'(interval_ff)) begin
               accum_in = '0;
               if (remaining_ff != 8'd0) begin
                  adv_in = 1'b1;
                  if (pending_ff < DEPTH_C) begin
                     mem_we    = 1'b1;
                     mem_waddr = (tail_sum >= DEPTH_A) ? AW'(tail_sum - DEPTH_A)
                                                        : tail_sum[AW-1:0];
                     mem_wdata = '0;
                     pend_tmp  = pending_ff + CW'(1);
                  end
                  pending_in   = pend_tmp;
                  remaining_in = (count_ff > 8'(pend_tmp)) ? count_ff - 8'(pend_tmp) : 8'd0;
               end
            end
            state_in = S_DONE;
         end

         // Hand the word to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = RSP_W'({pending_ff, remaining_ff, adv_ff, run_ff});
               last_count_in = count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Timer memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pending_age_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= pending_age_mem[mem_raddr];
      end
   end

   // Tick operands, loaded on acceptance.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
         cool_us_ff <= cool_us_in;
         fire_ff    <= fire_in;
      end
   end

   // Payload registers of the walk and the result.
   always_ff @(posedge clock) begin
      walk_idx_ff  <= walk_idx_in;
      walk_addr_ff <= walk_addr_in;
      expired_ff   <= expired_in;
      prefix_ff    <= prefix_in;
      run_ff       <= run_in;
      adv_ff       <= adv_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Control and tracker state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_count_ff <= '0;
         remaining_ff  <= '0;
         pending_ff    <= '0;
         head_ff       <= '0;
         accum_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_count_ff <= last_count_in;
         remaining_ff  <= remaining_in;
         pending_ff    <= pending_in;
         head_ff       <= head_in;
         accum_ff      <= accum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[verif/tb_shot_credit_tracker_unit.sv]
// Self-checking testbench for the shot credit tracker unit.
`timescale 1ns / 1ps

module tb_shot_credit_tracker_unit;

   localparam int DEPTH       = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   // One tick word, packed so that it matches req_tdata from bit 0 up.
   typedef struct packed {
      logic [sct_pkg::ELAPSED_W-1:0] elapsed_us;
      logic                          fire_held;
      logic                          referee_online;
      logic [sct_pkg::COOL_W-1:0]    cooling_seconds;
      logic [sct_pkg::COUNT_W-1:0]   reported_count;
   } tick_type;

   // One result word, packed so that it matches rsp_tdata from bit 0 up.
   typedef struct packed {
      logic [4:0]                  pending_count_out;
      logic [sct_pkg::COUNT_W-1:0] remaining_estimate;
      logic                        advance_one;
      logic                        motor_run;
   } tick_result_type;

   // Predicts the result of every tick and checks the words that come back.
   class credit_scoreboard_type;
      int unsigned max_valid;
      int unsigned offline_count;
      int unsigned interval;
      int unsigned prev_count;
      int unsigned remaining;
      int unsigned pending;
      int unsigned ages[DEPTH];
      int unsigned accum;
      tick_result_type owed_results[$];
      int failures;

      function new();
         max_valid     = sct_pkg::MAX_VALID_RESET;
         offline_count = sct_pkg::OFFLINE_RESET;
         interval      = sct_pkg::INTERVAL_RESET;
         prev_count    = 0;
         remaining     = 0;
         pending       = 0;
         accum         = 0;
         failures      = 0;
         foreach (ages[i]) ages[i] = 0;
      endfunction

      function void write_register(logic [1:0] index, int unsigned value);
         case (index)
            sct_pkg::CSR_MAX_VALID_COUNT:  max_valid = value & 32'hFF;
            sct_pkg::CSR_OFFLINE_DEFAULT:  offline_count = value & 32'hFF;
            sct_pkg::CSR_SHOT_INTERVAL_US: interval = value & 32'hFFFFF;
            default: ;
         endcase
      endfunction

      function int unsigned sat_add(int unsigned a, int unsigned b);
         int unsigned s;
         s = a + b;
         return (s > sct_pkg::TIME_MAX) ? int'(sct_pkg::TIME_MAX) : s;
      endfunction

      // Drops the n oldest pending shots and shifts the rest down.
      function void retire_oldest(int unsigned n);
         if (n >= pending) begin
            pending = 0;
            return;
         end
         pending -= n;
         for (int unsigned i = 0; i < pending; i++) ages[i] = ages[i + n];
      endfunction

      function void floor_remaining(int unsigned count);
         remaining = (count > pending) ? count - pending : 0;
      endfunction

      function void note_tick(tick_type t);
         int unsigned count;
         int unsigned cool_s;
         int unsigned cool_us;
         int unsigned elapsed;
         int unsigned expired;
         tick_result_type r;
         r = '0;
         elapsed = t.elapsed_us;

         // Filter the reported count.
         if (t.reported_count > max_valid) count = 0;
         else if (!t.referee_online) count = offline_count;
         else count = t.reported_count;
         cool_s = t.cooling_seconds;
         if (cool_s == 0) cool_s = sct_pkg::DEFAULT_COOLING_S;
         cool_us = cool_s * sct_pkg::US_PER_S;

         if (!t.fire_held) begin
            pending   = 0;
            remaining = count;
            accum     = 0;
         end else begin
            if (count < prev_count) retire_oldest(prev_count - count);
            floor_remaining(count);
            if (remaining < 1) begin
               accum = 0;
            end else begin
               r.motor_run = 1'b1;
               accum = sat_add(accum, elapsed);
               for (int unsigned i = 0; i < pending && i < DEPTH; i++)
                  ages[i] = sat_add(ages[i], elapsed);
               // Leading timers that reached the cooling time are retired.
               expired = 0;
               while (expired < pending && expired < DEPTH && ages[expired] >= cool_us)
                  expired++;
               if (expired > 0) begin
                  retire_oldest(expired);
                  floor_remaining(count);
               end
               // Scheduled feeder step; a full store still issues the step.
               if (accum >= interval) begin
                  accum = 0;
                  if (remaining >= 1) begin
                     r.advance_one = 1'b1;
                     if (pending < DEPTH) begin
                        ages[pending] = 0;
                        pending++;
                     end
                     floor_remaining(count);
                  end
               end
            end
         end
         prev_count = count;

         r.remaining_estimate = remaining[sct_pkg::COUNT_W-1:0];
         r.pending_count_out  = pending[4:0];
         owed_results.push_back(r);
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10) $display("%s", msg);
      endfunction

      function string describe(tick_result_type r);
         return $sformatf("run=%0d adv=%0d rem=%0d pend=%0d", r.motor_run, r.advance_one,
                          r.remaining_estimate, r.pending_count_out);
      endfunction

      function void check_result(tick_result_type got);
         tick_result_type want;
         if (owed_results.size() == 0) begin
            note_failure($sformatf("unexpected result word %h", got));
            return;
         end
         want = owed_results.pop_front();
         if (got.motor_run != want.motor_run || got.advance_one != want.advance_one ||
             got.remaining_estimate != want.remaining_estimate ||
             got.pending_count_out != want.pending_count_out)
            note_failure($sformatf("mismatch: expected %s, got %s",
                                   describe(want), describe(got)));
      endfunction

      function void flag_leftovers();
         if (owed_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", owed_results.size()));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic [39:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   credit_scoreboard_type board;
   int          sent_total;
   int          results_seen;
   int unsigned feed_count;
   int unsigned feed_cool;
   int unsigned cur_max;
   int unsigned cur_interval;

   shot_credit_tracker_unit #(.PENDING_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offers one tick word, with a random gap in front but for ticks 400 to 549, and waits for it to be taken.
   task automatic send_tick(input tick_type t);
      if (!(sent_total >= 400 && sent_total < 550)) begin
         while ($urandom_range(99) < 15) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      req_tdata  = {2'b00, t};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_tick(t);
      sent_total++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_fields(input int unsigned reported, input int unsigned cool,
                              input bit online, input bit fire, input int unsigned elapsed);
      tick_type t;
      t.reported_count  = sct_pkg::COUNT_W'(reported);
      t.cooling_seconds = sct_pkg::COOL_W'(cool);
      t.referee_online  = online;
      t.fire_held       = fire;
      t.elapsed_us      = sct_pkg::ELAPSED_W'(elapsed);
      send_tick(t);
   endtask

   // Mostly plausible firing sessions with a slowly falling count; the rest is noise.
   function automatic tick_type next_random_tick();
      tick_type t;
      int unsigned roll;
      if ($urandom_range(99) < 20) begin
         t.reported_count  = sct_pkg::COUNT_W'($urandom_range(255));
         t.cooling_seconds = sct_pkg::COOL_W'($urandom_range(255));
         t.referee_online  = 1'($urandom_range(1));
         t.fire_held       = 1'($urandom_range(1));
         t.elapsed_us      = sct_pkg::ELAPSED_W'($urandom_range(1000000));
         return t;
      end
      roll = $urandom_range(99);
      if (roll < 55) ;
      else if (roll < 80) feed_count = (feed_count > 0) ? feed_count - 1 : 0;
      else if (roll < 88) feed_count = (feed_count > 6) ? feed_count - $urandom_range(2, 6) : 0;
      else if (roll < 96) feed_count = $urandom_range(cur_max > 255 ? 255 : cur_max);
      else feed_count = $urandom_range(255);
      if ($urandom_range(99) < 5) begin
         case ($urandom_range(3))
            0: feed_cool = 0;
            1: feed_cool = 1;
            2: feed_cool = 2;
            default: feed_cool = $urandom_range(3, 255);
         endcase
      end
      roll = $urandom_range(99);
      t.reported_count  = sct_pkg::COUNT_W'(feed_count);
      t.cooling_seconds = sct_pkg::COOL_W'(feed_cool);
      t.referee_online  = ($urandom_range(99) < 95);
      t.fire_held       = ($urandom_range(99) < 92);
      if (roll < 50) t.elapsed_us = sct_pkg::ELAPSED_W'($urandom_range(cur_interval));
      else if (roll < 80) t.elapsed_us = sct_pkg::ELAPSED_W'($urandom_range(250000));
      else t.elapsed_us = sct_pkg::ELAPSED_W'($urandom_range(1000000));
      return t;
   endfunction

   task automatic send_random(input int n);
      for (int k = 0; k < n; k++) send_tick(next_random_tick());
   endtask

   task automatic wait_drained();
      while (board.owed_results.size() != 0) @(negedge clock);
   endtask

   // Register write: setup phase, then access phase.
   task automatic write_register(input logic [1:0] index, input int unsigned value);
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      csr_pwrite  = 1'b1;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_register(index, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic configure(input int unsigned max_count, input int unsigned off_count,
                            input int unsigned interval);
      wait_drained();
      write_register(sct_pkg::CSR_MAX_VALID_COUNT, max_count);
      write_register(sct_pkg::CSR_OFFLINE_DEFAULT, off_count);
      write_register(sct_pkg::CSR_SHOT_INTERVAL_US, interval);
      cur_max      = max_count;
      cur_interval = interval;
   endtask

   // Result side: random stalls, one long hold-off and a stretch without stalls.
   initial begin : result_sink
      bit held_off;
      held_off   = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && results_seen >= 250) begin
            held_off   = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready = (results_seen >= 420 && results_seen < 560) ||
                      ($urandom_range(99) >= 15);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(tick_result_type'(rsp_tdata[14:0]));
         results_seen++;
      end
   end

   // Ends the run when nothing moves on either stream for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb_shot_credit_tracker_unit: errors");
      $finish;
   end

   initial begin
      board        = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      sent_total   = 0;
      results_seen = 0;
      feed_count   = 120;
      feed_cool    = 1;
      cur_max      = sct_pkg::MAX_VALID_RESET;
      cur_interval = sct_pkg::INTERVAL_RESET;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Register defaults: filter limits, step timing and count drops.
      send_fields(50, 1, 1, 0, 0);          // fire released
      send_fields(201, 0, 1, 1, 500000);    // above the valid limit, nothing remaining
      send_fields(0, 3, 0, 1, 100000);      // offline default, one step
      send_fields(100, 3, 1, 1, 1000000);   // longest elapsed time
      send_fields(100, 3, 1, 1, 99999);     // just short of the interval
      send_fields(100, 3, 1, 1, 1);         // interval reached
      send_fields(98, 3, 1, 1, 0);          // drop retires the two oldest
      send_fields(60, 0, 1, 1, 0);          // drop beyond pending
      send_fields(255, 255, 1, 0, 1000000); // released while above the limit
      send_random(100);

      // Zero interval: a step every tick, also once the pending store is full.
      configure(255, 0, 0);
      repeat (17) send_fields(250, 255, 1, 1, 1000);
      send_fields(0, 255, 0, 1, 0);         // offline default of zero retires all
      send_random(80);

      configure(0, 255, 1);
      send_random(80);
      configure(255, 255, 1000000);
      send_random(120);

      // Pause mid-phase until every result has come back.
      configure(150, 20, 5000);
      send_random(75);
      wait_drained();
      send_random(75);

      repeat (3) begin
         configure($urandom_range(255), $urandom_range(255),
                   ($urandom_range(1) != 0) ? $urandom_range(1, 20000)
                                            : $urandom_range(20001, 1000000));
         send_random(110);
      end

      wait_drained();
      repeat (40) @(negedge clock);
      board.flag_leftovers();
      if (board.failures == 0) begin
         $display("tb_shot_credit_tracker_unit: clean");
      end else begin
         $display("tb_shot_credit_tracker_unit: errors");
      end
      $finish;
   end

endmodule
